@@ src/ita_pkg.sv @@
// Integer to ASCII formatter: shared package.
// Beat payload types, controller/datapath command and status structs, constants.
// No dependencies.
package ita_pkg;

   localparam int unsigned DIGIT_MAX = 10;
   localparam int unsigned PTR_W     = $clog2(DIGIT_MAX + 1);
   localparam int unsigned IDX_W     = $clog2(DIGIT_MAX);

   localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;
   localparam logic [3:0]  DEC_BASE   = 4'd10;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic MODE_DEC = 1'b0;
   localparam logic MODE_HEX = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic gen;
      logic push_sign;
      logic push_digit;
   } cmd_type;

   typedef struct packed {
      logic neg;
      logic gen_done;
      logic emit_done;
      logic out_free;
   } sts_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < DEC_BASE) begin
         c = CHAR_ZERO + {4'b0, d};
      end else begin
         c = CHAR_A + {4'b0, d} - {4'b0, DEC_BASE};
      end
      return c;
   endfunction

endpackage

@@ src/ita_ctrl.sv @@
// Integer to ASCII formatter: sequencing state machine.
// Drives datapath commands from datapath status. Depends on ita_pkg.
module ita_ctrl
   import ita_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_GEN  = 4'b0010,
      ST_SIGN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GEN;
            end
         end
         ST_GEN: begin
            cmd.gen = 1'b1;
            if (sts.gen_done) begin
               state_in = sts.neg ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               cmd.push_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.push_digit = 1'b1;
               if (sts.emit_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_sign_only_neg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> sts.neg)
      else $error("sign state entered for a non-negative number");

endmodule

@@ src/ita_dp.sv @@
// Integer to ASCII formatter: datapath.
// Magnitude, digit generator (reciprocal divide by ten or nibble split), digit
// store and output register. Depends on ita_pkg.
module ita_dp
   import ita_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [31:0]      mag_ff, mag_in;
   logic             hex_ff, hex_in;
   logic             neg_ff, neg_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [3:0]       digits_ff [DIGIT_MAX];
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [63:0]      prod;
   logic [31:0]      quot;
   logic [31:0]      rem_full;
   logic [3:0]       digit;
   logic [31:0]      mag_next;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] rd_idx;
   logic [PTR_W-1:0] rd_ptr;

   assign prod     = {32'b0, mag_ff} * {32'b0, RECIP_TEN};
   assign quot     = {3'b0, prod[63:RECIP_SHIFT]};
   assign rem_full = mag_ff - ((quot << 3) + (quot << 1));
   assign digit    = hex_ff ? mag_ff[3:0] : rem_full[3:0];
   assign mag_next = hex_ff ? (mag_ff >> 4) : quot;
   assign wr_idx   = ptr_ff[IDX_W-1:0];
   assign rd_ptr   = ptr_ff - PTR_W'(1);
   assign rd_idx   = rd_ptr[IDX_W-1:0];

   assign sts.neg       = neg_ff;
   assign sts.gen_done  = (mag_next == '0);
   assign sts.emit_done = (ptr_ff == PTR_W'(1));
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mag_in = mag_ff;
      hex_in = hex_ff;
      neg_in = neg_ff;
      ptr_in = ptr_ff;
      if (cmd.load) begin
         hex_in = (req_data.mode == MODE_HEX);
         neg_in = (req_data.mode == MODE_DEC) && req_data.value[31];
         mag_in = neg_in ? (~req_data.value + 32'd1) : req_data.value;
         ptr_in = '0;
      end else if (cmd.gen) begin
         mag_in = mag_next;
         ptr_in = ptr_ff + PTR_W'(1);
      end else if (cmd.push_digit) begin
         ptr_in = rd_ptr;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.push_sign) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = CHAR_MINUS;
         rsp_data_in.last      = 1'b0;
      end else if (cmd.push_digit) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.character = digit_char(digits_ff[rd_idx]);
         rsp_data_in.last      = sts.emit_done;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      hex_ff      <= hex_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.gen) begin
         digits_ff[wr_idx] <= digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_W'(DIGIT_MAX))
      else $error("digit count beyond store depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_sign || cmd.push_digit) |-> (!rsp_valid_ff || rsp_ready))
      else $error("held beat overwritten");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.push_digit |-> (ptr_ff != '0))
      else $error("digit popped from empty store");

endmodule

@@ src/integer_to_ascii_formatter_core.sv @@
// The accept cycle loads the number; its digits are then generated, least significant
// first, into the digit store, a minus sign is pushed for a negative decimal number,
// and the digits are emitted most significant first. Throughput: one character per
// cycle out while the receiver is ready; the next number is taken after the last beat.
// Reset (synchronous, active high) idles the controller and drops any held beat.
module integer_to_ascii_formatter_core
   import ita_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   ita_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ita_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/ita_char_checker.sv @@
// Character stream checker for the integer to ASCII formatter.
// Watches both channels, predicts the characters of each accepted number and
// compares every output beat in order. Depends on ita_pkg.
module ita_char_checker
   import ita_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   rsp_type char_q[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic void predict_chars(input logic mode, input logic [31:0] value);
      logic [7:0]  digits[12];
      logic [31:0] mag;
      logic [3:0]  d;
      logic        neg;
      int          n;
      neg = (mode == MODE_DEC) && value[31];
      mag = neg ? (~value + 32'd1) : value;
      n   = 0;
      do begin
         if (mode == MODE_HEX) begin
            d   = mag[3:0];
            mag = mag >> 4;
         end else begin
            d   = 4'(mag % 32'd10);
            mag = mag / 32'd10;
         end
         digits[n] = (d < 4'd10) ? (CHAR_ZERO + 8'(d)) : (CHAR_A + 8'(d) - 8'd10);
         n++;
      end while (mag != 0);
      if (neg) begin
         char_q.push_back('{character: CHAR_MINUS, last: 1'b0});
      end
      for (int k = n - 1; k >= 0; k--) begin
         char_q.push_back('{character: digits[k], last: (k == 0)});
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (char_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got char %h last %b",
                        $time, rsp_data.character, rsp_data.last);
               fail_count <= fail_count + 1;
            end else begin
               want = char_q.pop_front();
               if (want.character !== rsp_data.character) begin
                  $display("%0t: character mismatch, expected %h, got %h",
                           $time, want.character, rsp_data.character);
                  fail_count <= fail_count + 1;
               end else if (want.last !== rsp_data.last) begin
                  $display("%0t: last mismatch on %h, expected %b, got %b",
                           $time, want.character, want.last, rsp_data.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_chars(req_data.mode, req_data.value);
         end
      end
      pending <= char_q.size();
   end

endmodule

@@ tb/integer_to_ascii_formatter_core_tb.sv @@
// Top-level testbench for integer_to_ascii_formatter_core.
// Drives directed and random numbers under varying backpressure and reports
// the verdict from ita_char_checker. Depends on ita_pkg and the core RTL.
module integer_to_ascii_formatter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ita_pkg::*;

   localparam int PHASE_ITEMS  = 44;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   req_type directed_items[$] = '{
      '{MODE_DEC, 32'h0000_0000}, '{MODE_HEX, 32'h0000_0000},
      '{MODE_DEC, 32'h8000_0000}, '{MODE_HEX, 32'h8000_0000},
      '{MODE_DEC, 32'hFFFF_FFFF}, '{MODE_HEX, 32'hFFFF_FFFF},
      '{MODE_DEC, 32'h7FFF_FFFF}, '{MODE_HEX, 32'h7FFF_FFFF},
      '{MODE_DEC, 32'd9},         '{MODE_DEC, 32'd10},
      '{MODE_DEC, 32'd1000000000}, '{MODE_DEC, 32'hC465_3600},
      '{MODE_DEC, 32'hFFFF_FFF6}, '{MODE_HEX, 32'h0000_000F},
      '{MODE_HEX, 32'h0000_0010}, '{MODE_HEX, 32'h0000_000A},
      '{MODE_HEX, 32'h1234_5678}, '{MODE_HEX, 32'h9ABC_DEF0},
      '{MODE_DEC, 32'hAAAA_AAAA}, '{MODE_DEC, 32'h5555_5555}
   };

   integer_to_ascii_formatter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ita_char_checker char_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_number(input logic mode, input logic [31:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{mode: mode, value: value};
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [31:0] random_value();
      logic [31:0] p;
      logic [31:0] v;
      p = 32'd1;
      case ($urandom_range(4))
         0: v = $urandom;
         1: v = $urandom_range(99);
         2: v = -32'($urandom_range(100, 1));
         3: begin
            repeat ($urandom_range(9)) p = p * 32'd10;
            v = p + 32'($urandom_range(2)) - 32'd1;
            if ($urandom_range(1)) v = -v;
         end
         default: v = $urandom >> $urandom_range(31);
      endcase
      return v;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_items[i]) begin
         send_number(directed_items[i].mode, directed_items[i].value);
      end
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               recv_idle_pct = 64;
            end
            1: begin
               send_idle_pct = 64;
               recv_idle_pct = 7;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         repeat (PHASE_ITEMS) send_number(1'($urandom_range(1)), random_value());
      end
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/ita_pkg.sv
src/ita_ctrl.sv
src/ita_dp.sv
src/integer_to_ascii_formatter_core.sv
tb/ita_char_checker.sv
tb/integer_to_ascii_formatter_core_tb.sv
